FILE: hw/rtl/rne_pkg.sv
`timescale 1ns / 1ps

package rne_pkg;

    localparam int ValueWidth   = 12;
    localparam int SymWidth     = 7;
    localparam int NumPairs     = 13;
    localparam int PairIdxWidth = 4;
    localparam int QueueDepth   = 2;

    localparam logic [ValueWidth-1:0] ValueMax = 12'd3999;

    localparam logic [SymWidth-1:0] SymNone = 7'h00;
    localparam logic [SymWidth-1:0] SymI    = 7'h49;
    localparam logic [SymWidth-1:0] SymV    = 7'h56;
    localparam logic [SymWidth-1:0] SymX    = 7'h58;
    localparam logic [SymWidth-1:0] SymL    = 7'h4C;
    localparam logic [SymWidth-1:0] SymC    = 7'h43;
    localparam logic [SymWidth-1:0] SymD    = 7'h44;
    localparam logic [SymWidth-1:0] SymM    = 7'h4D;

    // One queued transaction: the value and its range check.
    typedef struct packed {
        logic [ValueWidth-1:0] value;
        logic                  err;
    } item_t;

    typedef struct packed {
        logic empty;
        logic full;
    } queue_status_t;

    function automatic logic [ValueWidth-1:0] pair_value(input logic [PairIdxWidth-1:0] idx);
        logic [ValueWidth-1:0] v;
        unique case (idx)
            4'd0:    v = 12'd1000;
            4'd1:    v = 12'd900;
            4'd2:    v = 12'd500;
            4'd3:    v = 12'd400;
            4'd4:    v = 12'd100;
            4'd5:    v = 12'd90;
            4'd6:    v = 12'd50;
            4'd7:    v = 12'd40;
            4'd8:    v = 12'd10;
            4'd9:    v = 12'd9;
            4'd10:   v = 12'd5;
            4'd11:   v = 12'd4;
            4'd12:   v = 12'd1;
            default: v = 12'd1;
        endcase
        return v;
    endfunction

    function automatic logic [SymWidth-1:0] pair_first(input logic [PairIdxWidth-1:0] idx);
        logic [SymWidth-1:0] s;
        unique case (idx)
            4'd0:    s = SymM;
            4'd1:    s = SymC;
            4'd2:    s = SymD;
            4'd3:    s = SymC;
            4'd4:    s = SymC;
            4'd5:    s = SymX;
            4'd6:    s = SymL;
            4'd7:    s = SymX;
            4'd8:    s = SymX;
            4'd9:    s = SymI;
            4'd10:   s = SymV;
            4'd11:   s = SymI;
            4'd12:   s = SymI;
            default: s = SymNone;
        endcase
        return s;
    endfunction

    // Second letter of a subtractive pair, SymNone for a single letter.
    function automatic logic [SymWidth-1:0] pair_second(input logic [PairIdxWidth-1:0] idx);
        logic [SymWidth-1:0] s;
        unique case (idx)
            4'd1:    s = SymM;
            4'd3:    s = SymD;
            4'd5:    s = SymC;
            4'd7:    s = SymL;
            4'd9:    s = SymX;
            4'd11:   s = SymV;
            default: s = SymNone;
        endcase
        return s;
    endfunction

endpackage

FILE: hw/rtl/roman_numeral_encoder.sv
`timescale 1ns / 1ps
// With the back part idle, an out-of-range value gives a single error result once it leaves
// the queue; otherwise the back part emits the letters of the numeral in order.
// A value leaves the queue only while the back part is idle; then each letter and each pair
// stepped past takes its own step, and an out-of-range value is answered from idle. The back
// part's one-pair-per-cycle sequencer, held by output stalls, sets the pace; a two-entry queue
// buffers inputs. Reset (rst_n, asynchronous, active low) empties the queue and drops output.

module roman_numeral_encoder
    import rne_pkg::*;
#(
    parameter int QUEUE_DEPTH = QueueDepth
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic [ValueWidth-1:0] value,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic [SymWidth-1:0]   symbol,
    output logic                  last,
    output logic                  error
);

    queue_status_t q_status;
    item_t         push_item;
    item_t         head_item;
    logic          push;
    logic          pop;

    rne_front u_front (
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .value     (value),
        .q_status  (q_status),
        .push      (push),
        .push_item (push_item)
    );

    rne_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .pop       (pop),
        .head_item (head_item),
        .q_status  (q_status)
    );

    rne_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_status  (q_status),
        .head_item (head_item),
        .pop       (pop),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .symbol    (symbol),
        .last      (last),
        .error     (error)
    );

endmodule

FILE: hw/rtl/rne_front.sv
`timescale 1ns / 1ps

module rne_front
    import rne_pkg::*;
(
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic [ValueWidth-1:0] value,
    input  queue_status_t         q_status,
    output logic                  push,
    output item_t                 push_item
);

    // Zero and anything past MMMCMXCIX are reported as a single error result.
    assign push_item.value = value;
    assign push_item.err   = (value == '0) || (value > ValueMax);

    assign in_stall = q_status.full;
    assign push     = in_valid && !q_status.full;

endmodule

FILE: hw/rtl/rne_queue.sv
`timescale 1ns / 1ps

module rne_queue
    import rne_pkg::*;
#(
    parameter int DEPTH = QueueDepth
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  item_t         push_item,
    input  logic          pop,
    output item_t         head_item,
    output queue_status_t q_status
);

    localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CntW = $clog2(DEPTH + 1);

    item_t            entry_reg [DEPTH];
    logic [PtrW-1:0]  wr_ptr_reg;
    logic [PtrW-1:0]  wr_ptr_next;
    logic [PtrW-1:0]  rd_ptr_reg;
    logic [PtrW-1:0]  rd_ptr_next;
    logic [CntW-1:0]  count_reg;
    logic [CntW-1:0]  count_next;
    logic             do_push;
    logic             do_pop;

    assign q_status.empty = (count_reg == '0);
    assign q_status.full  = (count_reg == CntW'(DEPTH));
    assign head_item      = entry_reg[rd_ptr_reg];

    assign do_push = push && !q_status.full;
    assign do_pop  = pop && !q_status.empty;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PtrW'(DEPTH - 1)) ? '0 : PtrW'(wr_ptr_reg + 1'b1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PtrW'(DEPTH - 1)) ? '0 : PtrW'(rd_ptr_reg + 1'b1);
        end
        if (do_push && !do_pop)
        begin
            count_next = CntW'(count_reg + 1'b1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = CntW'(count_reg - 1'b1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

FILE: hw/rtl/rne_back.sv
`timescale 1ns / 1ps

module rne_back
    import rne_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  queue_status_t       q_status,
    input  item_t               head_item,
    output logic                pop,
    output logic                out_valid,
    input  logic                out_stall,
    output logic [SymWidth-1:0] symbol,
    output logic                last,
    output logic                error
);

    typedef enum logic {
        S_IDLE,
        S_WORK
    } state_t;

    state_t                  state_reg;
    state_t                  state_next;
    logic [ValueWidth-1:0]   rest_reg;
    logic [ValueWidth-1:0]   rest_next;
    logic [PairIdxWidth-1:0] pair_reg;
    logic [PairIdxWidth-1:0] pair_next;
    logic                    second_reg;
    logic                    second_next;
    logic                    out_valid_reg;
    logic                    out_valid_next;
    logic [SymWidth-1:0]     symbol_reg;
    logic [SymWidth-1:0]     symbol_next;
    logic                    last_reg;
    logic                    last_next;
    logic                    error_reg;
    logic                    error_next;

    logic                    out_free;
    logic [ValueWidth-1:0]   cur_value;
    logic [ValueWidth-1:0]   rest_sub;

    assign out_free  = !out_valid_reg || !out_stall;
    assign cur_value = pair_value(pair_reg);
    assign rest_sub  = rest_reg - cur_value;
    assign pop       = (state_reg == S_IDLE) && !q_status.empty && out_free;

    assign out_valid = out_valid_reg;
    assign symbol    = symbol_reg;
    assign last      = last_reg;
    assign error     = error_reg;

    // One pair is examined per cycle while the output is not stalled; a pair that fits emits a
    // letter and stays current, so a repeated letter is emitted again before moving to the next pair.
    always_comb
    begin
        state_next     = state_reg;
        rest_next      = rest_reg;
        pair_next      = pair_reg;
        second_next    = second_reg;
        out_valid_next = out_valid_reg;
        symbol_next    = symbol_reg;
        last_next      = last_reg;
        error_next     = error_reg;
        if (out_free)
        begin
            out_valid_next = 1'b0;
            unique case (state_reg)
                S_IDLE:
                begin
                    if (pop)
                    begin
                        if (head_item.err)
                        begin
                            out_valid_next = 1'b1;
                            symbol_next    = SymNone;
                            last_next      = 1'b1;
                            error_next     = 1'b1;
                        end
                        else
                        begin
                            state_next  = S_WORK;
                            rest_next   = head_item.value;
                            pair_next   = '0;
                            second_next = 1'b0;
                        end
                    end
                end
                S_WORK:
                begin
                    priority if (second_reg)
                    begin
                        // The pair's value was already taken off with its first letter.
                        out_valid_next = 1'b1;
                        symbol_next    = pair_second(pair_reg);
                        last_next      = (rest_reg == '0);
                        error_next     = 1'b0;
                        second_next    = 1'b0;
                        if (rest_reg == '0)
                        begin
                            state_next = S_IDLE;
                        end
                    end
                    else if (rest_reg >= cur_value)
                    begin
                        out_valid_next = 1'b1;
                        symbol_next    = pair_first(pair_reg);
                        error_next     = 1'b0;
                        rest_next      = rest_sub;
                        if (pair_second(pair_reg) != SymNone)
                        begin
                            second_next = 1'b1;
                            last_next   = 1'b0;
                        end
                        else
                        begin
                            last_next = (rest_sub == '0);
                            if (rest_sub == '0)
                            begin
                                state_next = S_IDLE;
                            end
                        end
                    end
                    else
                    begin
                        pair_next = PairIdxWidth'(pair_reg + 1'b1);
                    end
                end
                default:
                begin
                    state_next = S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            rest_reg      <= '0;
            pair_reg      <= '0;
            second_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
            symbol_reg    <= SymNone;
            last_reg      <= 1'b0;
            error_reg     <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rest_reg      <= rest_next;
            pair_reg      <= pair_next;
            second_reg    <= second_next;
            out_valid_reg <= out_valid_next;
            symbol_reg    <= symbol_next;
            last_reg      <= last_next;
            error_reg     <= error_next;
        end
    end

`ifndef NO_ASSERTIONS
    a_error_is_single: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && error_reg |-> last_reg && (symbol_reg == SymNone))
        else $error("error transaction not a single last result");

    a_second_in_work: assert property (@(posedge clk) disable iff (!rst_n)
        second_reg |-> (state_reg == S_WORK))
        else $error("pending second letter outside of work state");

    a_pair_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_WORK) |-> (pair_reg < PairIdxWidth'(NumPairs)))
        else $error("pair index ran past the last pair");

    a_work_has_rest: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_WORK) && !second_reg |-> (rest_reg != '0))
        else $error("work state with nothing left to emit");

    a_last_ends_work: assert property (@(posedge clk) disable iff (!rst_n)
        out_free && (state_reg == S_WORK) && (state_next == S_IDLE) |=> out_valid_reg && last_reg)
        else $error("numeral ended without a last letter");
`endif

endmodule
